// File: rtl/ames_pkg.sv
// ----------------------------------------------------------------------------
// Adjacency matrix edge store package
// Shared sizes, operation codes and the command and result words that pass
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package ames_pkg;

  localparam int MaxNodes      = 16;
  localparam int NodeW         = 4;
  localparam int Cells         = MaxNodes * MaxNodes;
  localparam int CellW         = 2 * NodeW;
  localparam int CountW        = 5;
  localparam int FuncW         = 4;
  localparam int FieldWeightW  = 16;
  localparam int FieldLabelW   = 8;
  localparam int InDataW       = 40;
  localparam int OutDataW      = 40;
  localparam int DefWeightBits = 16;
  localparam int DefLabelBits  = 8;
  localparam int QueueDepth    = 2;
  localparam int QueuePtrW     = 1;

  typedef enum logic [FuncW-1:0] {
    OP_ADD        = 4'd0,
    OP_REMOVE     = 4'd1,
    OP_TEST       = 4'd2,
    OP_SET_WEIGHT = 4'd3,
    OP_GET_WEIGHT = 4'd4,
    OP_SET_ELABEL = 4'd5,
    OP_GET_ELABEL = 4'd6,
    OP_SET_NLABEL = 4'd7,
    OP_GET_NLABEL = 4'd8,
    OP_NEXT       = 4'd9,
    OP_NONE       = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACCESS,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                     op;
    logic                    bad;
    logic [NodeW-1:0]        from_node;
    logic [NodeW-1:0]        to_node;
    logic [NodeW:0]          start_col;
    logic [FieldWeightW-1:0] weight;
    logic [FieldLabelW-1:0]  label;
  } cmd_t;

  typedef struct packed {
    logic                    bad_index;
    logic [NodeW-1:0]        next_to;
    logic [NodeW-1:0]        next_from;
    logic                    found;
    logic [FieldLabelW-1:0]  label_out;
    logic [FieldWeightW-1:0] weight_out;
    logic                    edge_present;
  } res_t;

endpackage

// File: rtl/adjacency_matrix_edge_store.sv
// ----------------------------------------------------------------------------
// Adjacency matrix edge store
// Directed-graph edge store with weights and labels per edge and labels per
// node, plus a row-major next-edge search.
//
// The slave stream takes one command word per handshake: tuser is the
// function code, tdata the node indexes and write data. The master stream
// returns exactly one result word per command, in order. The node count is
// written through cfg_we_i/cfg_wdata_i; the user must write it only while no
// command is in flight, which the block itself does not enforce. The write
// clears every edge and node label beyond the new count. Edge and label
// commands pass through an access step before the result is loaded; rejected
// or unknown codes skip it. A next-edge search scans one matrix row per cycle
// and takes the access step only when it finds an edge. The back end works
// on one command at a time.
// A two-word queue holds up to two commands while the back end is busy or
// the master side is stalled; a stalled result holds in its output register.
// After reset the node count is zero, every edge is absent and every label
// reads zero; commands are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module adjacency_matrix_edge_store #(
  parameter int WeightBits = ames_pkg::DefWeightBits,
  parameter int LabelBits  = ames_pkg::DefLabelBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ames_pkg::CountW-1:0]   cfg_wdata_i,    // node_count
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [ames_pkg::FuncW-1:0]    s_axis_tuser_i, // func
  // from_node[3:0], to_node[7:4], start_of_row[8], weight_in[24:9],
  // label_in[32:25]
  input  logic [ames_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // edge_present[0], weight_out[16:1], label_out[24:17], found[25],
  // next_from[29:26], next_to[33:30], bad_index[34]
  output logic [ames_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import ames_pkg::*;

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  cmd_t              front_cmd;
  cmd_t              back_cmd;
  logic [CountW-1:0] node_count;
  res_t              res;

  ames_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .node_count_i    (node_count),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (front_cmd)
  );

  ames_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (back_cmd)
  );

  ames_back #(
    .WeightBits (WeightBits),
    .LabelBits  (LabelBits)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .node_count_o    (node_count),
    .q_valid_i       (q_valid),
    .q_cmd_i         (back_cmd),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .res_o           (res)
  );

  assign m_axis_tdata_o = OutDataW'(res);

endmodule

// File: rtl/ames_front.sv
// ----------------------------------------------------------------------------
// Adjacency matrix edge store front end
// Unpacks the input word, checks node indexes against the node count and
// turns the function code into a command for the queue.
// ----------------------------------------------------------------------------
module ames_front (
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [ames_pkg::FuncW-1:0]   s_axis_tuser_i,
  input  logic [ames_pkg::InDataW-1:0] s_axis_tdata_i,
  input  logic [ames_pkg::CountW-1:0]  node_count_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output ames_pkg::cmd_t               q_cmd_o
);
  import ames_pkg::*;

  logic [NodeW-1:0] from_node;
  logic [NodeW-1:0] to_node;
  logic             start_of_row;
  logic             from_bad;
  logic             to_bad;
  logic             bad;
  op_e              func;

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    func         = op_e'(s_axis_tuser_i);
    from_node    = s_axis_tdata_i[3:0];
    to_node      = s_axis_tdata_i[7:4];
    start_of_row = s_axis_tdata_i[8];
    from_bad     = {1'b0, from_node} >= node_count_i;
    to_bad       = {1'b0, to_node} >= node_count_i;
    bad          = 1'b0;

    case (func)
      OP_ADD, OP_REMOVE, OP_TEST, OP_SET_WEIGHT, OP_GET_WEIGHT,
      OP_SET_ELABEL, OP_GET_ELABEL: begin
        bad = from_bad || to_bad;
      end
      OP_SET_NLABEL, OP_GET_NLABEL: begin
        bad = from_bad;
      end
      OP_NEXT: begin
        bad = from_bad || (!start_of_row && to_bad);
      end
      default: begin
        bad = 1'b0;
      end
    endcase

    q_cmd_o.bad       = bad;
    q_cmd_o.from_node = from_node;
    q_cmd_o.to_node   = to_node;
    q_cmd_o.start_col = start_of_row ? '0 : {1'b0, to_node} + 5'd1;
    q_cmd_o.weight    = s_axis_tdata_i[24:9];
    q_cmd_o.label     = s_axis_tdata_i[32:25];

    case (func)
      OP_ADD, OP_REMOVE, OP_TEST, OP_SET_WEIGHT, OP_GET_WEIGHT,
      OP_SET_ELABEL, OP_GET_ELABEL, OP_SET_NLABEL, OP_GET_NLABEL,
      OP_NEXT: begin
        q_cmd_o.op = bad ? OP_NONE : func;
      end
      default: begin
        q_cmd_o.op = OP_NONE;
      end
    endcase
  end

endmodule

// File: rtl/ames_queue.sv
// ----------------------------------------------------------------------------
// Adjacency matrix edge store command queue
// Short FIFO of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
module ames_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ames_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ames_pkg::cmd_t cmd_o
);
  import ames_pkg::*;

  cmd_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]   count_q, count_d;

  assign full_o  = count_q == (QueuePtrW + 1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QueuePtrW + 1)'(push_i) - (QueuePtrW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: rtl/ames_back.sv
// ----------------------------------------------------------------------------
// Adjacency matrix edge store back end
// Holds the node count, the edge matrix and the labels, carries out one
// command at a time, scans one matrix row a cycle for next-edge searches
// and keeps the result word in an output register.
// ----------------------------------------------------------------------------
module ames_back #(
  parameter int WeightBits = ames_pkg::DefWeightBits,
  parameter int LabelBits  = ames_pkg::DefLabelBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ames_pkg::CountW-1:0] cfg_wdata_i,
  output logic [ames_pkg::CountW-1:0] node_count_o,
  input  logic                        q_valid_i,
  input  ames_pkg::cmd_t              q_cmd_i,
  output logic                        q_pop_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output ames_pkg::res_t              res_o
);
  import ames_pkg::*;

  state_e                  state_q, state_d;
  logic [CountW-1:0]       node_count_q;
  logic [CountW-1:0]       cfg_count;
  cmd_t                    cmd_q;
  logic [NodeW-1:0]        row_q;
  logic [NodeW:0]          col_q;
  logic [CellW-1:0]        pos_q;
  logic                    found_q;

  logic [Cells-1:0]        exists_q;
  logic [Cells-1:0]        live_q;
  logic [Cells-1:0]        keep;
  logic [LabelBits-1:0]    node_label_q [MaxNodes];

  logic signed [WeightBits-1:0] weight_mem [Cells];
  logic [LabelBits-1:0]         label_mem  [Cells];
  logic signed [WeightBits-1:0] wrd_q;
  logic [LabelBits-1:0]         lrd_q;
  logic signed [WeightBits-1:0] wstore;
  logic [LabelBits-1:0]         lstore;
  logic signed [WeightBits-1:0] wmem_wdata;
  logic [LabelBits-1:0]         lmem_wdata;

  logic [MaxNodes-1:0]     row_bits;
  logic [MaxNodes-1:0]     mask;
  logic                    hit;
  logic [NodeW-1:0]        hit_col;
  logic                    last_row;

  logic                    exists_set;
  logic                    exists_clr;
  logic                    live_set;
  logic                    wmem_we;
  logic                    lmem_we;
  logic                    nlabel_we;
  logic                    out_load;

  logic                    out_vld_q;
  res_t                    res_q, res_d;

  assign node_count_o    = node_count_q;
  assign m_axis_tvalid_o = out_vld_q;
  assign res_o           = res_q;
  assign wstore          = WeightBits'($signed(cmd_q.weight));
  assign lstore          = LabelBits'(cmd_q.label);
  assign wmem_wdata      = (cmd_q.op == OP_SET_ELABEL) ? '0 : wstore;
  assign lmem_wdata      = (cmd_q.op == OP_SET_ELABEL) ? lstore : '0;
  assign cfg_count       = (cfg_wdata_i > CountW'(MaxNodes)) ? CountW'(MaxNodes) : cfg_wdata_i;

  // row scan
  always_comb begin
    row_bits = exists_q[{row_q, {NodeW{1'b0}}} +: MaxNodes];
    for (int c = 0; c < MaxNodes; c++) begin
      mask[c] = row_bits[c] && ((NodeW + 1)'(c) >= col_q) && (CountW'(c) < node_count_q);
    end
    hit     = |mask;
    hit_col = '0;
    for (int c = MaxNodes - 1; c >= 0; c--) begin
      if (mask[c]) begin
        hit_col = NodeW'(c);
      end
    end
    last_row = ({1'b0, row_q} + 5'd1) >= node_count_q;
  end

  always_comb begin
    for (int k = 0; k < Cells; k++) begin
      keep[k] = (CountW'(k >> NodeW) < cfg_count) && (CountW'(k & (MaxNodes - 1)) < cfg_count);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_cmd_i.op == OP_NEXT) begin
            state_d = ST_SCAN;
          end else if (q_cmd_i.op == OP_NONE) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_ACCESS;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = ST_ACCESS;
        end else if (last_row) begin
          state_d = ST_DONE;
        end
      end
      ST_ACCESS: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    q_pop_o    = 1'b0;
    exists_set = 1'b0;
    exists_clr = 1'b0;
    live_set   = 1'b0;
    wmem_we    = 1'b0;
    lmem_we    = 1'b0;
    nlabel_we  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        q_pop_o = q_valid_i;
      end
      ST_ACCESS: begin
        exists_set = cmd_q.op == OP_ADD;
        exists_clr = cmd_q.op == OP_REMOVE;
        live_set   = (cmd_q.op == OP_ADD) || (cmd_q.op == OP_SET_WEIGHT) ||
                     (cmd_q.op == OP_SET_ELABEL);
        wmem_we    = (cmd_q.op == OP_ADD) || (cmd_q.op == OP_SET_WEIGHT) ||
                     ((cmd_q.op == OP_SET_ELABEL) && !live_q[pos_q]);
        lmem_we    = (cmd_q.op == OP_ADD) || (cmd_q.op == OP_SET_ELABEL) ||
                     ((cmd_q.op == OP_SET_WEIGHT) && !live_q[pos_q]);
        nlabel_we  = cmd_q.op == OP_SET_NLABEL;
      end
      ST_DONE: begin
        out_load = !out_vld_q || m_axis_tready_i;
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_count;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // hold the command and advance the scan position
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_valid_i) begin
      cmd_q   <= q_cmd_i;
      row_q   <= q_cmd_i.from_node;
      col_q   <= q_cmd_i.start_col;
      pos_q   <= {q_cmd_i.from_node, q_cmd_i.to_node};
      found_q <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      if (hit) begin
        pos_q   <= {row_q, hit_col};
        found_q <= 1'b1;
      end else begin
        row_q <= row_q + 1'b1;
        col_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exists_q <= '0;
      live_q   <= '0;
    end else if (cfg_we_i) begin
      exists_q <= exists_q & keep;
      live_q   <= live_q & keep;
    end else begin
      if (exists_set) begin
        exists_q[pos_q] <= 1'b1;
      end
      if (exists_clr) begin
        exists_q[pos_q] <= 1'b0;
      end
      if (live_set) begin
        live_q[pos_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MaxNodes; r++) begin
        node_label_q[r] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int r = 0; r < MaxNodes; r++) begin
        if (CountW'(r) >= cfg_count) begin
          node_label_q[r] <= '0;
        end
      end
    end else if (nlabel_we) begin
      node_label_q[cmd_q.from_node] <= lstore;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wmem_we) begin
      weight_mem[pos_q] <= wmem_wdata;
    end
    wrd_q <= weight_mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (lmem_we) begin
      label_mem[pos_q] <= lmem_wdata;
    end
    lrd_q <= label_mem[pos_q];
  end

  // result word
  always_comb begin
    res_d           = '0;
    res_d.bad_index = cmd_q.bad;
    case (cmd_q.op)
      OP_ADD, OP_REMOVE, OP_TEST: begin
        res_d.edge_present = exists_q[pos_q];
      end
      OP_SET_WEIGHT: begin
        res_d.edge_present = exists_q[pos_q];
        res_d.weight_out   = FieldWeightW'(wstore);
      end
      OP_GET_WEIGHT: begin
        res_d.edge_present = exists_q[pos_q];
        res_d.weight_out   = live_q[pos_q] ? FieldWeightW'(wrd_q) : '0;
      end
      OP_SET_ELABEL: begin
        res_d.edge_present = exists_q[pos_q];
        res_d.label_out    = FieldLabelW'(lstore);
      end
      OP_GET_ELABEL: begin
        res_d.edge_present = exists_q[pos_q];
        res_d.label_out    = live_q[pos_q] ? FieldLabelW'(lrd_q) : '0;
      end
      OP_SET_NLABEL: begin
        res_d.label_out = FieldLabelW'(lstore);
      end
      OP_GET_NLABEL: begin
        res_d.label_out = FieldLabelW'(node_label_q[cmd_q.from_node]);
      end
      OP_NEXT: begin
        if (found_q) begin
          res_d.edge_present = 1'b1;
          res_d.weight_out   = live_q[pos_q] ? FieldWeightW'(wrd_q) : '0;
          res_d.label_out    = live_q[pos_q] ? FieldLabelW'(lrd_q) : '0;
          res_d.found        = 1'b1;
          res_d.next_from    = pos_q[CellW-1:NodeW];
          res_d.next_to      = pos_q[NodeW-1:0];
        end
      end
      default: begin
        res_d.edge_present = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
  end

endmodule
